@@ sv/lpag_pkg.sv @@
// ----------------------------------------------------------------------------
// lpag_pkg
// Types and constants shared by the line pixel address generator.
// ----------------------------------------------------------------------------
package lpag_pkg;

	localparam int InW        = 12;  // signed endpoint coordinate
	localparam int PosW       = 11;  // clamped coordinate before the 10-bit mask
	localparam int CoordW     = 10;
	localparam int OffW       = 23;
	localparam int LenW       = 12;
	localparam int ColorW     = 32;
	localparam int DimW       = 11;
	localparam int PitchW     = 14;
	localparam int BppW       = 3;
	localparam int RowOffW    = CoordW + PitchW;
	localparam int LimW       = 13;  // holds a dimension limit up to 4096
	localparam int CfgIdxW    = 2;
	localparam int CfgDataW   = 14;
	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = $clog2(QueueDepth);

	localparam logic [DimW-1:0]   WidthReset  = DimW'(320);
	localparam logic [DimW-1:0]   HeightReset = DimW'(200);
	localparam logic [PitchW-1:0] PitchReset  = PitchW'(640);
	localparam logic [BppW-1:0]   BppReset    = BppW'(2);

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_TICK  = 1'b1
	} cmd_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_PITCH  = 2'd2,
		REG_BPP    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [DimW-1:0]   width;
		logic [DimW-1:0]   height;
		logic [PitchW-1:0] pitch;
		logic [BppW-1:0]   bpp;
	} cfg_t;

	// one classified command as it waits between front and back
	typedef struct packed {
		cmd_t              cmd;
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
		logic              x_neg;
		logic              y_neg;
		logic              major_is_x;
		logic [LenW-1:0]   major_len;
		logic [LenW-1:0]   minor_len;
		logic [OffW-1:0]   offset;
		logic [ColorW-1:0] color;
	} line_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

@@ sv/lpag_if.sv @@
// ----------------------------------------------------------------------------
// lpag_if
// Valid/ready channels of the line pixel address generator: commands in,
// pixels out, and the register write port.
// ----------------------------------------------------------------------------
interface lpag_item_if
	import lpag_pkg::*;
	();
	logic                     valid;
	logic                     ready;
	logic                     command;
	logic signed [InW-1:0]    x_start;
	logic signed [InW-1:0]    y_start;
	logic signed [InW-1:0]    x_end;
	logic signed [InW-1:0]    y_end;
	logic        [ColorW-1:0] draw_color;

	modport source (output valid, command, x_start, y_start, x_end, y_end, draw_color,
		input ready);
	modport sink (input valid, command, x_start, y_start, x_end, y_end, draw_color,
		output ready);
endinterface

interface lpag_pixel_if
	import lpag_pkg::*;
	();
	logic              valid;
	logic              ready;
	logic [CoordW-1:0] pixel_x;
	logic [CoordW-1:0] pixel_y;
	logic [OffW-1:0]   byte_offset;
	logic [ColorW-1:0] pixel_color;
	logic              last;

	modport source (output valid, pixel_x, pixel_y, byte_offset, pixel_color, last,
		input ready);
	modport sink (input valid, pixel_x, pixel_y, byte_offset, pixel_color, last,
		output ready);
endinterface

interface lpag_cfg_if
	import lpag_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ sv/line_pixel_address_generator_top.sv @@
// ----------------------------------------------------------------------------
// line_pixel_address_generator_top
// Bresenham line rasterizer producing pixel coordinates and byte offsets.
// ----------------------------------------------------------------------------
// Usage:
//   item   - command channel. A start command (command = 0) latches two
//            endpoints, clamped to the screen, and a color; it gives no pixel.
//            A tick (command = 1) emits the next pixel of the current line;
//            a tick with no line in progress is dropped.
//   pixels - one transaction per pixel: x, y, byte offset, color, last.
//   cfg    - register writes (width, height, pitch, bytes per pixel); always
//            ready. Write only while no command is in flight.
// Timing: one command per cycle while pixels.ready holds. A pixel passes,
//   after its tick is accepted, through two front stages (clamp, then classify
//   with the y*pitch multiply), the command queue, and the back end's stepping
//   unit, which handles one command per cycle into the output register.
// Reset: registers take 320 x 200, pitch 640, two bytes per pixel; no line.
// Stall: the output register holds its pixel, the four-entry queue fills,
//   and item.ready drops once the front stages are full as well.
// ----------------------------------------------------------------------------
module line_pixel_address_generator_top
	import lpag_pkg::*;
#(
	parameter int MAX_DIM = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	lpag_cfg_if.sink     cfg,
	lpag_item_if.sink    item,
	lpag_pixel_if.source pixels
);

	cfg_t          cfg_q;
	queue_status_t qstat;
	logic          push, pop;
	line_entry_t   push_entry, pop_entry;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= WidthReset;
			cfg_q.height <= HeightReset;
			cfg_q.pitch  <= PitchReset;
			cfg_q.bpp    <= BppReset;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_WIDTH:  cfg_q.width  <= cfg.data[DimW-1:0];
				REG_HEIGHT: cfg_q.height <= cfg.data[DimW-1:0];
				REG_PITCH:  cfg_q.pitch  <= cfg.data[PitchW-1:0];
				REG_BPP:    cfg_q.bpp    <= cfg.data[BppW-1:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	lpag_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item      (item),
		.qstat     (qstat),
		.push      (push),
		.push_entry(push_entry)
	);

	lpag_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.pop_entry (pop_entry),
		.qstat     (qstat)
	);

	lpag_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.qstat    (qstat),
		.pop_entry(pop_entry),
		.pop      (pop),
		.pixels   (pixels)
	);

endmodule

@@ sv/lpag_front.sv @@
// ----------------------------------------------------------------------------
// lpag_front
// Accepts commands, clamps endpoints, works out direction, axis lengths and
// the start byte offset, and pushes one entry per command into the queue.
// ----------------------------------------------------------------------------
module lpag_front
	import lpag_pkg::*;
#(
	parameter int MAX_DIM = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	lpag_item_if.sink     item,
	input  queue_status_t qstat,
	output logic          push,
	output line_entry_t   push_entry
);

	localparam logic [LimW-1:0] MaxDimL = LimW'(MAX_DIM);

	function automatic logic [PosW-1:0] clamp_coord(input logic signed [InW-1:0] c,
		input logic [DimW-1:0] dim);
		logic [LimW-1:0] lim;
		logic [LimW-1:0] hi;
		logic [PosW-1:0] res;
		lim = (dim == '0) ? LimW'(1) : LimW'(dim);
		if (lim > MaxDimL) lim = MaxDimL;
		hi = lim - LimW'(1);
		if (c[InW-1]) res = '0;
		else if (LimW'(c[PosW-1:0]) > hi) res = hi[PosW-1:0];
		else res = c[PosW-1:0];
		return res;
	endfunction

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [PosW-1:0]   x1_s1, y1_s1, x2_s1, y2_s1;
	logic [ColorW-1:0] color_s1;

	logic              valid_s2;
	line_entry_t       entry_s2;

	logic              adv_s2, load_s2;
	line_entry_t       entry_d;

	logic signed [InW-1:0] dx, dy;
	logic [LenW-1:0]       adx, ady;
	logic [RowOffW-1:0]    row_off;
	logic [RowOffW-1:0]    col_off;
	logic                  x_major;

	assign adv_s2     = valid_s2 && !qstat.full;
	assign load_s2    = valid_s1 && (!valid_s2 || adv_s2);
	assign item.ready = !valid_s1 || load_s2;
	assign push       = valid_s2;
	assign push_entry = entry_s2;

	// stage 1: clamp endpoints
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			cmd_s1   <= cmd_t'(item.command);
			x1_s1    <= clamp_coord(item.x_start, cfg.width);
			y1_s1    <= clamp_coord(item.y_start, cfg.height);
			x2_s1    <= clamp_coord(item.x_end, cfg.width);
			y2_s1    <= clamp_coord(item.y_end, cfg.height);
			color_s1 <= item.draw_color;
		end
	end

	// stage 2: classify the line and find its start offset
	always_comb begin
		dx      = $signed({1'b0, x2_s1}) - $signed({1'b0, x1_s1});
		dy      = $signed({1'b0, y2_s1}) - $signed({1'b0, y1_s1});
		adx     = (dx[InW-1] ? LenW'(-dx) : LenW'(dx)) + LenW'(1);
		ady     = (dy[InW-1] ? LenW'(-dy) : LenW'(dy)) + LenW'(1);
		x_major = adx >= ady;
		row_off = RowOffW'(y1_s1[CoordW-1:0]) * RowOffW'(cfg.pitch);
		col_off = RowOffW'(x1_s1[CoordW-1:0]) * RowOffW'(cfg.bpp);

		entry_d.cmd        = cmd_s1;
		entry_d.x          = x1_s1[CoordW-1:0];
		entry_d.y          = y1_s1[CoordW-1:0];
		entry_d.x_neg      = dx[InW-1];
		entry_d.y_neg      = dy[InW-1];
		entry_d.major_is_x = x_major;
		entry_d.major_len  = x_major ? adx : ady;
		entry_d.minor_len  = x_major ? ady : adx;
		entry_d.offset     = OffW'(row_off + col_off);
		entry_d.color      = color_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			entry_s2 <= entry_d;
		end
	end

endmodule

@@ sv/lpag_queue.sv @@
// ----------------------------------------------------------------------------
// lpag_queue
// Short FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
module lpag_queue
	import lpag_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  line_entry_t   push_entry,
	input  logic          pop,
	output line_entry_t   pop_entry,
	output queue_status_t qstat
);

	line_entry_t            entries_q [QueueDepth];
	logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QueuePtrW:0]     count_q;
	logic                   do_push, do_pop;

	assign qstat.full  = count_q == (QueuePtrW+1)'(QueueDepth);
	assign qstat.empty = count_q == '0;
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign pop_entry   = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QueuePtrW+1)'(1);
				2'b01:   count_q <= count_q - (QueuePtrW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

@@ sv/lpag_back.sv @@
// ----------------------------------------------------------------------------
// lpag_back
// Holds the line in progress, steps it once per tick and presents each pixel
// in an output register.
// ----------------------------------------------------------------------------
module lpag_back
	import lpag_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  queue_status_t qstat,
	input  line_entry_t   pop_entry,
	output logic          pop,
	lpag_pixel_if.source  pixels
);

	logic              busy_q;
	logic [CoordW-1:0] cur_x_q, cur_y_q;
	logic [OffW-1:0]   cur_off_q;
	logic [LenW-1:0]   err_q, major_q, minor_q, left_q;
	logic              major_is_x_q, x_neg_q, y_neg_q;
	logic [ColorW-1:0] color_q;

	logic              out_valid_q;
	logic [CoordW-1:0] out_x_q, out_y_q;
	logic [OffW-1:0]   out_off_q;
	logic [ColorW-1:0] out_color_q;
	logic              out_last_q;

	logic              is_last, minor_step, step_x, step_y, emit;
	logic [LenW-1:0]   err_sum, err_next;
	logic [CoordW-1:0] x_next, y_next;
	logic [OffW-1:0]   x_delta, y_delta, off_next;

	assign pop  = !qstat.empty && (!out_valid_q || pixels.ready);
	assign emit = pop && (pop_entry.cmd == CMD_TICK) && busy_q;

	always_comb begin
		is_last    = left_q <= LenW'(1);
		err_sum    = err_q + minor_q;
		minor_step = err_sum >= major_q;
		err_next   = minor_step ? err_sum - major_q : err_sum;
		step_x     = major_is_x_q || minor_step;
		step_y     = !major_is_x_q || minor_step;
		x_next     = cur_x_q;
		y_next     = cur_y_q;
		x_delta    = '0;
		y_delta    = '0;
		if (step_x) begin
			x_next  = x_neg_q ? cur_x_q - CoordW'(1) : cur_x_q + CoordW'(1);
			x_delta = x_neg_q ? -OffW'(cfg.bpp) : OffW'(cfg.bpp);
		end
		if (step_y) begin
			y_next  = y_neg_q ? cur_y_q - CoordW'(1) : cur_y_q + CoordW'(1);
			y_delta = y_neg_q ? -OffW'(cfg.pitch) : OffW'(cfg.pitch);
		end
		off_next = cur_off_q + x_delta + y_delta;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			cur_off_q    <= '0;
			err_q        <= '0;
			major_q      <= '0;
			minor_q      <= '0;
			left_q       <= '0;
			major_is_x_q <= 1'b0;
			x_neg_q      <= 1'b0;
			y_neg_q      <= 1'b0;
			color_q      <= '0;
		end else if (pop) begin
			if (pop_entry.cmd == CMD_START) begin
				// abandon any line in progress
				busy_q       <= 1'b1;
				cur_x_q      <= pop_entry.x;
				cur_y_q      <= pop_entry.y;
				cur_off_q    <= pop_entry.offset;
				err_q        <= '0;
				major_q      <= pop_entry.major_len;
				minor_q      <= pop_entry.minor_len;
				left_q       <= pop_entry.major_len;
				major_is_x_q <= pop_entry.major_is_x;
				x_neg_q      <= pop_entry.x_neg;
				y_neg_q      <= pop_entry.y_neg;
				color_q      <= pop_entry.color;
			end else if (busy_q) begin
				if (is_last) begin
					busy_q <= 1'b0;
					left_q <= '0;
				end else begin
					left_q    <= left_q - LenW'(1);
					err_q     <= err_next;
					cur_x_q   <= x_next;
					cur_y_q   <= y_next;
					cur_off_q <= off_next;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pixels.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_x_q     <= cur_x_q;
			out_y_q     <= cur_y_q;
			out_off_q   <= cur_off_q;
			out_color_q <= color_q;
			out_last_q  <= is_last;
		end
	end

	assign pixels.valid       = out_valid_q;
	assign pixels.pixel_x     = out_x_q;
	assign pixels.pixel_y     = out_y_q;
	assign pixels.byte_offset = out_off_q;
	assign pixels.pixel_color = out_color_q;
	assign pixels.last        = out_last_q;

endmodule
